/* sv/mhpq_pkg.sv */
package mhpq_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    // child index arithmetic: 2*pos+2 must not wrap
    localparam int KID_W      = IDX_W + 2;

    localparam int FIELD_W = 16;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 6;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_value;
        logic [STAT_W-1:0]  status;
        logic [OCC_W-1:0]   occupancy;
    } t_out;

endpackage

/* sv/mhpq_ram.sv */
module mhpq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/min_heap_priority_queue_top.sv */
// Binary min-heap priority queue, 32 entries of 16 bits.
// Command channel: present i_cmd with start high; the command is taken at a
// clock edge where start is high and busy is low. mode 0 pushes push_value,
// mode 1 pops the smallest entry.
// Result channel: o_done is high for exactly one cycle with o_result valid;
// the receiver cannot stall, so every result must be taken in that cycle.
// Each result carries the popped value (zero unless popped), a status
// (pushed, popped, push dropped full, pop on empty) and the occupancy after
// the command.
// A full push or an empty pop is answered from idle; a push climbs the heap
// level by level, a pop reads the root and the last entry, then descends.
// Each heap level costs one read of the single-port-read heap memory plus a
// compare, and on the way down a read of each child (the right one only
// when it exists).
// busy stays high until the result cycle, and a new command may be taken in
// the very cycle o_done is shown.
// Reset clears the entry count and the sequencer; memory contents are left
// as they are, since only entries below the count are ever read.
module min_heap_priority_queue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mhpq_pkg::t_in  i_cmd,
    output logic           busy,
    output logic           o_done,
    output mhpq_pkg::t_out o_result
);
    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PU_RD   = 4'd1;
    localparam logic [3:0] S_PU_CMP  = 4'd2;
    localparam logic [3:0] S_PO_ROOT = 4'd3;
    localparam logic [3:0] S_PO_LAST = 4'd4;
    localparam logic [3:0] S_DN_L    = 4'd5;
    localparam logic [3:0] S_DN_R    = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;

    logic [3:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [VALUE_BITS-1:0] r_left, n_left;
    logic [VALUE_BITS-1:0] r_popped, n_popped;
    logic                  r_done, n_done;
    t_out                  r_res, n_res;

    logic                  we, re;
    logic [IDX_W-1:0]      waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;

    logic                  accept;
    logic [IDX_W-1:0]      parent;
    logic [KID_W-1:0]      kid_l, kid_r, cnt_w;
    logic                  has_l, has_r, take_r;
    logic [VALUE_BITS-1:0] pick;
    logic [IDX_W-1:0]      pick_idx;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign accept   = start && (r_state == S_IDLE);
    assign parent   = IDX_W'((r_pos - IDX_W'(1)) >> 1);
    assign kid_l    = KID_W'({r_pos, 1'b1});
    assign kid_r    = kid_l + KID_W'(1);
    assign cnt_w    = KID_W'(r_count);
    assign has_l    = kid_l < cnt_w;
    assign has_r    = kid_r < cnt_w;
    // left child wins a tie
    assign take_r   = has_r && (r_left > rdata);
    assign pick     = take_r ? rdata : r_left;
    assign pick_idx = take_r ? kid_r[IDX_W-1:0] : kid_l[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_val    = r_val;
        n_left   = r_left;
        n_popped = r_popped;
        n_done   = 1'b0;
        n_res    = r_res;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_val;
        re       = 1'b0;
        raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.mode == MODE_PUSH) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            // drop the beat, heap unchanged
                            n_done = 1'b1;
                            n_res  = '{popped_value: '0, status: ST_FULL,
                                       occupancy: OCC_W'(r_count)};
                        end else begin
                            n_val   = i_cmd.push_value[VALUE_BITS-1:0];
                            n_pos   = r_count[IDX_W-1:0];
                            n_count = r_count + CNT_W'(1);
                            n_state = S_PU_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done = 1'b1;
                            n_res  = '{popped_value: '0, status: ST_EMPTY,
                                       occupancy: '0};
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            re      = 1'b1;
                            raddr   = '0;
                            n_state = S_PO_ROOT;
                        end
                    end
                end
            end
            S_PU_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_done  = 1'b1;
                    n_res   = '{popped_value: '0, status: ST_PUSHED,
                                occupancy: OCC_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = parent;
                    n_state = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                we = 1'b1;
                if (rdata <= r_val) begin
                    n_done  = 1'b1;
                    n_res   = '{popped_value: '0, status: ST_PUSHED,
                                occupancy: OCC_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    // move the parent down into the hole
                    wdata   = rdata;
                    n_pos   = parent;
                    n_state = S_PU_RD;
                end
            end
            S_PO_ROOT: begin
                n_popped = rdata;
                re       = 1'b1;
                raddr    = r_count[IDX_W-1:0];
                n_state  = S_PO_LAST;
            end
            S_PO_LAST: begin
                n_val   = rdata;
                n_pos   = '0;
                n_state = S_DN_L;
            end
            S_DN_L: begin
                if (!has_l) begin
                    we      = 1'b1;
                    n_done  = 1'b1;
                    n_res   = '{popped_value: FIELD_W'(r_popped), status: ST_POPPED,
                                occupancy: OCC_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = kid_l[IDX_W-1:0];
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                n_left  = rdata;
                re      = has_r;
                raddr   = kid_r[IDX_W-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (pick > r_val) begin
                    n_done  = 1'b1;
                    n_res   = '{popped_value: FIELD_W'(r_popped), status: ST_POPPED,
                                occupancy: OCC_W'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    // lift the smaller child into the hole
                    wdata   = pick;
                    n_pos   = pick_idx;
                    n_state = S_DN_L;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_left   <= n_left;
        r_popped <= n_popped;
        r_res    <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |->
            (o_result.occupancy == OCC_W'(CAPACITY)))
        else $error("full status with heap not full");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |->
            (o_result.occupancy == '0 && o_result.popped_value == '0))
        else $error("empty status with entries or value");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted beat neither answered nor in progress");

endmodule
